// ----- hdl/ccs_pkg.sv -----
// Shared constants and types for the comparison counting sort chain.
`default_nettype none
package ccs_pkg;

  localparam int unsigned MAX_ITEMS = 64;
  localparam int unsigned KEY_BITS  = 16;
  localparam int unsigned FIELD_BITS = 16;
  localparam int unsigned CNT_W     = $clog2(MAX_ITEMS + 1);

  typedef logic [KEY_BITS-1:0] key_t;
  typedef logic [CNT_W-1:0]    cnt_t;

  // Chain operation for the current cycle.
  typedef struct packed {
    logic load;    // insert new_key into the sorted row
    logic unload;  // shift the row toward the head by one
  } ccs_ctrl_t;

endpackage
`default_nettype wire

// ----- hdl/ccs_cell.sv -----
// One cell of the sorting row: holds a key and its valid bit.
`default_nettype none
module ccs_cell (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire ccs_pkg::ccs_ctrl_t ctrl_i,
  input  wire ccs_pkg::key_t     new_key_i,
  input  wire ccs_pkg::key_t     left_key_i,
  input  wire logic              left_valid_i,
  input  wire logic              left_shift_i,
  input  wire ccs_pkg::key_t     right_key_i,
  input  wire logic              right_valid_i,
  output ccs_pkg::key_t          key_o,
  output logic                   valid_o,
  output logic                   shift_o
);
  import ccs_pkg::*;

  key_t key_q, key_d;
  logic valid_q, valid_d;

  // Row is kept descending; a new key goes behind every key >= it,
  // so this cell and all cells after it move one place back.
  assign shift_o = !valid_q || (key_q < new_key_i);

  always_comb begin
    key_d   = key_q;
    valid_d = valid_q;
    if (ctrl_i.unload) begin
      key_d   = right_key_i;
      valid_d = right_valid_i;
    end else if (ctrl_i.load && shift_o) begin
      if (left_shift_i) begin
        key_d   = left_key_i;
        valid_d = left_valid_i;
      end else begin
        key_d   = new_key_i;
        valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign key_o   = key_q;
  assign valid_o = valid_q;

endmodule
`default_nettype wire

// ----- hdl/ccs_chain.sv -----
// Row of MAX_ITEMS sorting cells wired to their neighbors.
`default_nettype none
module ccs_chain (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire ccs_pkg::ccs_ctrl_t ctrl_i,
  input  wire ccs_pkg::key_t      new_key_i,
  output ccs_pkg::key_t           head_key_o
);
  import ccs_pkg::*;

  key_t key_w   [MAX_ITEMS];
  logic valid_w [MAX_ITEMS];
  logic shift_w [MAX_ITEMS];

  for (genvar k = 0; k < MAX_ITEMS; k++) begin : g_row
    key_t l_key, r_key;
    logic l_valid, l_shift, r_valid;

    if (k == 0) begin : g_first
      assign l_key   = '0;
      assign l_valid = 1'b0;
      assign l_shift = 1'b0;
    end else begin : g_mid
      assign l_key   = key_w[k-1];
      assign l_valid = valid_w[k-1];
      assign l_shift = shift_w[k-1];
    end

    if (k == MAX_ITEMS - 1) begin : g_last
      assign r_key   = '0;
      assign r_valid = 1'b0;
    end else begin : g_inner
      assign r_key   = key_w[k+1];
      assign r_valid = valid_w[k+1];
    end

    ccs_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl_i),
      .new_key_i    (new_key_i),
      .left_key_i   (l_key),
      .left_valid_i (l_valid),
      .left_shift_i (l_shift),
      .right_key_i  (r_key),
      .right_valid_i(r_valid),
      .key_o        (key_w[k]),
      .valid_o      (valid_w[k]),
      .shift_o      (shift_w[k])
    );
  end

  assign head_key_o = key_w[0];

endmodule
`default_nettype wire

// ----- hdl/comparison_counting_sort_top.sv -----
// Top level: load/drain control around the sorting cell row.
// Each key is inserted in sorted place in the cycle it is transferred, one key per
// cycle while loading; keys beyond MAX_ITEMS are dropped. After the final key,
// results stream from the head cell, one per cycle unless out_stall_i holds them,
// first valid the cycle after the final transfer; input is stalled while draining.
// Reset (async, active low) clears state, fill count and all cell valid bits.
`default_nettype none
module comparison_counting_sort_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [15:0] key_value_i,
  input  wire logic        final_key_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  output logic [15:0]      sorted_value_o,
  output logic             final_output_o,
  output logic             out_valid_o,
  input  wire logic        out_stall_i
);
  import ccs_pkg::*;

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } state_e;

  state_e    state_q;
  cnt_t      cnt_q;
  ccs_ctrl_t ctrl;
  key_t      head_key;
  logic      in_xfer, out_xfer, room;

  assign in_stall_o  = (state_q == ST_DRAIN);
  assign out_valid_o = (state_q == ST_DRAIN);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_xfer    = out_valid_o && !out_stall_i;
  assign room        = cnt_q < CNT_W'(MAX_ITEMS);

  assign ctrl.load   = in_xfer && room;
  assign ctrl.unload = out_xfer;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      cnt_q   <= '0;
    end else begin
      unique case (state_q)
        ST_LOAD: begin
          if (in_xfer) begin
            if (room) begin
              cnt_q <= cnt_q + CNT_W'(1);
            end
            if (final_key_i) begin
              state_q <= ST_DRAIN;
            end
          end
        end
        ST_DRAIN: begin
          if (out_xfer) begin
            cnt_q <= cnt_q - CNT_W'(1);
            if (cnt_q == CNT_W'(1)) begin
              state_q <= ST_LOAD;
            end
          end
        end
        default: state_q <= ST_LOAD;
      endcase
    end
  end

  ccs_chain u_chain (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .new_key_i (key_value_i[KEY_BITS-1:0]),
    .head_key_o(head_key)
  );

  assign sorted_value_o = FIELD_BITS'(head_key);
  assign final_output_o = (cnt_q == CNT_W'(1));

  // Draining always has at least one key left.
  a_drain_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (cnt_q != '0))
    else $error("drain with empty row");

  // Fill count never passes the row length.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_ITEMS))
    else $error("fill count overflow");

  // Transfer of the last result ends the drain.
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_xfer && final_output_o) |=> (!out_valid_o && (cnt_q == '0)))
    else $error("drain did not end after last result");

  // Final input transfer starts a drain in the next cycle.
  a_final_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && final_key_i) |=> out_valid_o)
    else $error("final key did not start drain");

endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
// Testbench for comparison_counting_sort_top: key sets in, descending sorted stream out.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
  import ccs_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned SETTLE_CYCLES = 200;
  localparam int unsigned KEY_TARGET = 470;
  localparam int unsigned DIR_ROWS = 20;

  typedef struct packed {
    key_t value;
    logic last;
  } sorted_out_t;

  // Directed row; want is used only where typed is set (single-key sets).
  typedef struct packed {
    key_t key;
    logic fin;
    logic typed;
    key_t want;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic [15:0] key_value_i;
  logic        final_key_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [15:0] sorted_value_o;
  logic        final_output_o;
  logic        out_valid_o;
  logic        out_stall_i;

  // Sideband that travels with the payload to the monitor.
  logic drv_typed;
  key_t drv_want;

  key_t        held_keys[$];
  sorted_out_t pending_sorted[$];
  int unsigned mismatch_cnt;
  int unsigned cycle_cnt;
  int unsigned stored_cnt;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  comparison_counting_sort_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .key_value_i    (key_value_i),
    .final_key_i    (final_key_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .sorted_value_o (sorted_value_o),
    .final_output_o (final_output_o),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Rank by pairwise comparison: the later key wins the rank bump on ties,
  // which yields a descending order that keeps equal keys in load order.
  task automatic accept_key(input key_t k, input logic fin, input logic typed,
                            input key_t want);
    logic [5:0] rank [MAX_ITEMS];
    key_t       placed [MAX_ITEMS];
    int         n;
    int         i;
    int         j;
    if (held_keys.size() < MAX_ITEMS) held_keys.push_back(k);
    if (fin) begin
      n = held_keys.size();
      for (i = 0; i < n; i++) rank[i] = '0;
      for (i = 1; i < n; i++) begin
        for (j = 0; j < i; j++) begin
          if (held_keys[i] <= held_keys[j]) rank[i] = rank[i] + 1'b1;
          else rank[j] = rank[j] + 1'b1;
        end
      end
      for (i = 0; i < n; i++) placed[rank[i]] = held_keys[i];
      if (typed) begin
        pending_sorted.push_back('{value: want, last: 1'b1});
      end else begin
        for (i = 0; i < n; i++) pending_sorted.push_back('{value: placed[i], last: (i == n - 1)});
      end
      held_keys.delete();
    end
  endtask

  task automatic check_result(input key_t v, input logic l);
    sorted_out_t due;
    if (pending_sorted.size() == 0) begin
      if (mismatch_cnt < 10) $display("unexpected result: value %h last %b", v, l);
      mismatch_cnt++;
    end else begin
      due = pending_sorted.pop_front();
      if (due.value !== v || due.last !== l) begin
        if (mismatch_cnt < 10) begin
          $display("mismatch: expected value %h last %b, got value %h last %b",
                   due.value, due.last, v, l);
        end
        mismatch_cnt++;
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) accept_key(key_value_i, final_key_i, drv_typed, drv_want);
      if (out_valid_o && !out_stall_i) check_result(sorted_value_o, final_output_o);
    end
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // Idle mix follows progress: slow receiver, then slow sender, then full rate.
  task automatic set_pressure();
    if (stored_cnt < 160) begin
      send_idle_pct = 19;
      recv_stall_pct = 65;
    end else if (stored_cnt < 320) begin
      send_idle_pct = 65;
      recv_stall_pct = 19;
    end else begin
      send_idle_pct = 0;
      recv_stall_pct = 0;
    end
  endtask

  task automatic send_key(input key_t k, input logic fin, input logic typed,
                          input key_t want, input logic kept);
    set_pressure();
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    key_value_i <= k;
    final_key_i <= fin;
    drv_typed   <= typed;
    drv_want    <= want;
    do @(posedge clk_i); while (in_stall_o);
    if (kept) stored_cnt++;
  endtask

  function automatic key_t pick_key(input int unsigned mode);
    case (mode)
      0: pick_key = key_t'($urandom_range(0, 3));  // dense ties
      1: begin
        case ($urandom_range(0, 2))
          0: pick_key = '0;
          1: pick_key = '1;
          default: pick_key = key_t'($urandom);
        endcase
      end
      default: pick_key = key_t'($urandom);
    endcase
  endfunction

  dir_row_t    dir_rows [DIR_ROWS];
  int unsigned set_no;
  int unsigned set_len;
  int unsigned mode;
  int unsigned r;
  int unsigned k;

  initial begin
    dir_rows = '{
      '{16'hFFFF, 1'b1, 1'b1, 16'hFFFF},  // lone max key
      '{16'h0000, 1'b1, 1'b1, 16'h0000},  // lone min key
      '{16'h1234, 1'b0, 1'b0, 16'h0000},
      '{16'h8000, 1'b0, 1'b0, 16'h0000},
      '{16'h1234, 1'b0, 1'b0, 16'h0000},
      '{16'h0001, 1'b1, 1'b0, 16'h0000},
      '{16'h0000, 1'b0, 1'b0, 16'h0000},
      '{16'hFFFF, 1'b1, 1'b0, 16'h0000},
      '{16'h5555, 1'b0, 1'b0, 16'h0000},  // all-equal set
      '{16'h5555, 1'b0, 1'b0, 16'h0000},
      '{16'h5555, 1'b1, 1'b0, 16'h0000},
      '{16'h0001, 1'b0, 1'b0, 16'h0000},  // already ascending
      '{16'h0002, 1'b0, 1'b0, 16'h0000},
      '{16'h0003, 1'b0, 1'b0, 16'h0000},
      '{16'h0004, 1'b1, 1'b0, 16'h0000},
      '{16'hAAAA, 1'b0, 1'b0, 16'h0000},
      '{16'h5555, 1'b0, 1'b0, 16'h0000},
      '{16'hFFFF, 1'b0, 1'b0, 16'h0000},
      '{16'h0000, 1'b1, 1'b0, 16'h0000},
      '{16'h8000, 1'b1, 1'b1, 16'h8000}
    };
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    key_value_i = '0;
    final_key_i = 1'b0;
    out_stall_i = 1'b0;
    drv_typed = 1'b0;
    drv_want = '0;
    mismatch_cnt = 0;
    cycle_cnt = 0;
    stored_cnt = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIR_ROWS; i++) begin
      send_key(dir_rows[i].key, dir_rows[i].fin, dir_rows[i].typed, dir_rows[i].want, 1'b1);
    end

    // Random sets: mostly short, a full set and two overflowing ones mixed in.
    set_no = 0;
    while (stored_cnt < KEY_TARGET) begin
      if (set_no == 0) set_len = 66;
      else if (set_no == 6) set_len = MAX_ITEMS;
      else if (set_no == 14) set_len = 70;
      else begin
        r = $urandom_range(0, 9);
        set_len = (r < 7) ? $urandom_range(1, 8) : $urandom_range(9, 24);
      end
      mode = $urandom_range(0, 3);
      for (k = 0; k < set_len; k++) begin
        send_key(pick_key(mode), (k == set_len - 1), 1'b0, '0, (k < MAX_ITEMS));
      end
      set_no++;
    end
    in_valid_i <= 1'b0;

    while (pending_sorted.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    mismatch_cnt += pending_sorted.size();
    if (mismatch_cnt == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
`default_nettype wire
